>>> rtl/core/longest_prefix_route_lookup_macros.svh
// Assertion helpers for the route lookup block.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_MACROS_SVH

// Checked on a given clock and active-low reset.
`define LPR_ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on aclk, quiet while aresetn is low.
`define LPR_ASSERT(label, prop, msg) \
    `LPR_ASSERT_AT(label, aclk, aresetn, prop, msg)

`endif

>>> rtl/core/lpr_pkg.sv
package lpr_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_PORT_COUNT  = 4;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] hop_addr;
        logic [1:0]  port;
    } route_entry_t;

    typedef struct packed {
        logic         en;
        route_entry_t entry;
    } route_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } lpr_state_t;

endpackage

>>> rtl/core/lpr_table.sv
module lpr_table #(
    parameter int TABLE_DEPTH = lpr_pkg::DEF_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                 aclk,
    input  lpr_pkg::route_wr_t   wr,
    input  logic [AW-1:0]        waddr,
    input  logic                 rd_en,
    input  logic [AW-1:0]        raddr,
    output lpr_pkg::route_entry_t rdata
);

    lpr_pkg::route_entry_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[waddr] <= wr.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/lpr_ctrl.sv
module lpr_ctrl #(
    parameter int TABLE_DEPTH = lpr_pkg::DEF_TABLE_DEPTH,
    parameter int PORT_COUNT  = lpr_pkg::DEF_PORT_COUNT,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [10:0]           entries_in_use,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [9:0]            s_entry_index,
    input  logic [31:0]           s_route_prefix_in,
    input  logic [31:0]           s_route_mask_in,
    input  logic [31:0]           s_next_hop_in,
    input  logic [1:0]            s_port_in,
    input  logic [31:0]           s_dest_addr,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [31:0]           m_next_hop_out,
    output logic [1:0]            m_port_out,
    output logic [9:0]            m_match_index,
    output lpr_pkg::route_wr_t    tbl_wr,
    output logic [AW-1:0]         tbl_waddr,
    output logic                  tbl_rd_en,
    output logic [AW-1:0]         tbl_raddr,
    input  lpr_pkg::route_entry_t tbl_rdata
);

    lpr_pkg::lpr_state_t state_reg, state_next;

    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [31:0]   dest_reg, dest_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          hit_reg, hit_next;
    logic [31:0]   best_mask_reg, best_mask_next;
    logic [31:0]   best_hop_reg, best_hop_next;
    logic [1:0]    best_port_reg, best_port_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_found_reg, m_found_next;
    logic [31:0]   m_hop_reg, m_hop_next;
    logic [1:0]    m_port_reg, m_port_next;
    logic [9:0]    m_idx_reg, m_idx_next;

    logic          start;
    logic          load_out;
    logic          last_addr;
    logic          better;
    logic [CW-1:0] limit_in;

    always_comb begin
        if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
            limit_in = CW'(TABLE_DEPTH);
        end else begin
            limit_in = CW'(entries_in_use);
        end
    end

    assign last_addr = (32'(addr_reg) + 32'd1) == 32'(limit_reg);
    assign better    = rd_valid_reg
                     && ((dest_reg & tbl_rdata.mask) == tbl_rdata.prefix)
                     && (!hit_reg || (tbl_rdata.mask > best_mask_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpr_pkg::ST_IDLE: begin
                if (s_valid && s_op == lpr_pkg::OP_LOOKUP) begin
                    state_next = (limit_in == '0) ? lpr_pkg::ST_DONE : lpr_pkg::ST_SCAN;
                end
            end
            lpr_pkg::ST_SCAN: begin
                if (last_addr) begin
                    state_next = lpr_pkg::ST_DRAIN;
                end
            end
            lpr_pkg::ST_DRAIN: begin
                state_next = lpr_pkg::ST_DONE;
            end
            lpr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = lpr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        tbl_rd_en = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            lpr_pkg::ST_IDLE:  s_ready   = 1'b1;
            lpr_pkg::ST_SCAN:  tbl_rd_en = 1'b1;
            lpr_pkg::ST_DRAIN: ;
            lpr_pkg::ST_DONE:  load_out  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign start = s_ready && s_valid && (s_op == lpr_pkg::OP_LOOKUP);

    // table write
    always_comb begin
        tbl_wr.en             = s_ready && s_valid && (s_op == lpr_pkg::OP_WRITE)
                              && (32'(s_entry_index) < 32'(TABLE_DEPTH));
        tbl_wr.entry.prefix   = s_route_prefix_in;
        tbl_wr.entry.mask     = s_route_mask_in;
        tbl_wr.entry.hop_addr = s_next_hop_in;
        if (32'(s_port_in) >= 32'(PORT_COUNT)) begin
            tbl_wr.entry.port = 2'(PORT_COUNT - 1);
        end else begin
            tbl_wr.entry.port = s_port_in;
        end
    end

    assign tbl_waddr = AW'(s_entry_index);
    assign tbl_raddr = addr_reg;

    // scan datapath
    always_comb begin
        addr_next      = addr_reg;
        limit_next     = limit_reg;
        dest_next      = dest_reg;
        rd_valid_next  = tbl_rd_en;
        rd_idx_next    = addr_reg;
        hit_next       = hit_reg;
        best_mask_next = best_mask_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        best_idx_next  = best_idx_reg;
        if (start) begin
            addr_next  = '0;
            limit_next = limit_in;
            dest_next  = s_dest_addr;
            hit_next   = 1'b0;
        end else begin
            if (tbl_rd_en) begin
                addr_next = addr_reg + AW'(1);
            end
            if (better) begin
                hit_next       = 1'b1;
                best_mask_next = tbl_rdata.mask;
                best_hop_next  = tbl_rdata.hop_addr;
                best_port_next = tbl_rdata.port;
                best_idx_next  = rd_idx_reg;
            end
        end
    end

    // output word
    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_hop_next   = m_hop_reg;
        m_port_next  = m_port_reg;
        m_idx_next   = m_idx_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_found_next = hit_reg;
            m_hop_next   = hit_reg ? best_hop_reg : '0;
            m_port_next  = hit_reg ? best_port_reg : '0;
            m_idx_next   = hit_reg ? 10'(best_idx_reg) : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lpr_pkg::ST_IDLE;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            hit_reg      <= hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        limit_reg     <= limit_next;
        dest_reg      <= dest_next;
        rd_idx_reg    <= rd_idx_next;
        best_mask_reg <= best_mask_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        best_idx_reg  <= best_idx_next;
        m_found_reg   <= m_found_next;
        m_hop_reg     <= m_hop_next;
        m_port_reg    <= m_port_next;
        m_idx_reg     <= m_idx_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_next_hop_out = m_hop_reg;
    assign m_port_out     = m_port_reg;
    assign m_match_index  = m_idx_reg;

endmodule

>>> rtl/core/longest_prefix_route_lookup.sv
// IPv4 longest-prefix route lookup. A write word (op 0) stores prefix, mask, next hop
// and port at entry_index; a lookup word (op 1) scans entries 0 to entries_in_use-1
// through the table's single read port, one entry per cycle, and returns the matching
// entry with the largest mask (lowest index on a tie), or found = 0 with all fields
// zero. A lookup holds off new words through its scan, drain and done states, going
// straight to done when the table is empty; the result waits in an output register,
// so the next word is taken while it is still pending. Entries inside the searched
// range must be written before a lookup. The user must write entries_in_use on the
// cfg port only while no lookup is in flight and no result is pending; the block
// itself does not enforce this. Values above the table depth act as the depth.
`include "longest_prefix_route_lookup_macros.svh"

module longest_prefix_route_lookup #(
    parameter int TABLE_DEPTH = lpr_pkg::DEF_TABLE_DEPTH,
    parameter int PORT_COUNT  = lpr_pkg::DEF_PORT_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [9:0]  s_entry_index,
    input  logic [31:0] s_route_prefix_in,
    input  logic [31:0] s_route_mask_in,
    input  logic [31:0] s_next_hop_in,
    input  logic [1:0]  s_port_in,
    input  logic [31:0] s_dest_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [31:0] m_next_hop_out,
    output logic [1:0]  m_port_out,
    output logic [9:0]  m_match_index
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [10:0] entries_in_use_reg, entries_in_use_next;

    lpr_pkg::route_wr_t    tbl_wr;
    logic [AW-1:0]         tbl_waddr;
    logic                  tbl_rd_en;
    logic [AW-1:0]         tbl_raddr;
    lpr_pkg::route_entry_t tbl_rdata;

    assign cfg_ready = 1'b1;

    always_comb begin
        entries_in_use_next = entries_in_use_reg;
        if (cfg_valid && cfg_ready) begin
            entries_in_use_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= '0;
        end else begin
            entries_in_use_reg <= entries_in_use_next;
        end
    end

    lpr_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .wr    (tbl_wr),
        .waddr (tbl_waddr),
        .rd_en (tbl_rd_en),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    lpr_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .PORT_COUNT (PORT_COUNT)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .entries_in_use    (entries_in_use_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_entry_index     (s_entry_index),
        .s_route_prefix_in (s_route_prefix_in),
        .s_route_mask_in   (s_route_mask_in),
        .s_next_hop_in     (s_next_hop_in),
        .s_port_in         (s_port_in),
        .s_dest_addr       (s_dest_addr),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_next_hop_out    (m_next_hop_out),
        .m_port_out        (m_port_out),
        .m_match_index     (m_match_index),
        .tbl_wr            (tbl_wr),
        .tbl_waddr         (tbl_waddr),
        .tbl_rd_en         (tbl_rd_en),
        .tbl_raddr         (tbl_raddr),
        .tbl_rdata         (tbl_rdata)
    );

    `LPR_ASSERT(a_lookup_busy, (s_valid && s_ready && s_op == lpr_pkg::OP_LOOKUP) |=> !s_ready, "lookup word did not block input")
    `LPR_ASSERT(a_write_no_word, (s_valid && s_ready && s_op == lpr_pkg::OP_WRITE && !m_valid) |=> !m_valid, "write word produced a result")
    `LPR_ASSERT(a_miss_zero, (m_valid && !m_found) |-> (m_next_hop_out == '0 && m_port_out == '0 && m_match_index == '0), "miss result not zeroed")
    `LPR_ASSERT(a_port_range, (m_valid && m_found) |-> (32'(m_port_out) < 32'(PORT_COUNT)), "port beyond port count")
    `LPR_ASSERT(a_no_write_in_scan, tbl_rd_en |-> !tbl_wr.en, "table write during scan")

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = lpr_pkg::DEF_TABLE_DEPTH;
    localparam int PORTS       = lpr_pkg::DEF_PORT_COUNT;
    localparam int LONG_HOLD   = 2000;
    localparam int STALL_LIMIT = 20000;

    typedef enum int {PLAIN, HOLD_RX, PAUSE_TX} pressure_t;

    typedef struct packed {
        logic        op;
        logic [9:0]  idx;
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [1:0]  port;
        logic [31:0] dest;
    } route_word_t;

    typedef struct packed {
        logic        found;
        logic [31:0] hop;
        logic [1:0]  port;
        logic [9:0]  idx;
    } route_answer_t;

    class route_checker_t;
        logic [31:0] prefix_tab [DEPTH];
        logic [31:0] mask_tab   [DEPTH];
        logic [31:0] hop_tab    [DEPTH];
        logic [1:0]  port_tab   [DEPTH];
        int unsigned span;
        route_answer_t pending_answers [$];
        int mismatches;
        int lookups;
        int hits;
        int misses;
        int writes;

        function new();
            span       = 0;
            mismatches = 0;
            lookups    = 0;
            hits       = 0;
            misses     = 0;
            writes     = 0;
        endfunction

        function void set_span(int unsigned v);
            span = v;
        endfunction

        function int unsigned searched();
            return (span > DEPTH) ? DEPTH : span;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        // longest mask wins, lowest index on a tie
        function void note_word(route_word_t w);
            route_answer_t a;
            logic [31:0]   best_mask;
            int unsigned   i;
            if (w.op == lpr_pkg::OP_WRITE) begin
                writes++;
                if (w.idx < DEPTH) begin
                    prefix_tab[w.idx] = w.prefix;
                    mask_tab[w.idx]   = w.mask;
                    hop_tab[w.idx]    = w.hop;
                    port_tab[w.idx]   = (w.port >= PORTS) ? 2'(PORTS - 1) : w.port;
                end
            end else begin
                lookups++;
                a         = '0;
                best_mask = '0;
                for (i = 0; i < searched(); i++) begin
                    if ((w.dest & mask_tab[i]) == prefix_tab[i] &&
                        (!a.found || mask_tab[i] > best_mask)) begin
                        a.found   = 1'b1;
                        a.hop     = hop_tab[i];
                        a.port    = port_tab[i];
                        a.idx     = 10'(i);
                        best_mask = mask_tab[i];
                    end
                end
                if (a.found) hits++;
                else misses++;
                pending_answers.push_back(a);
            end
        endfunction

        function void check_answer(route_answer_t got);
            route_answer_t want;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected answer: found=%0b hop=%h port=%0d index=%0d",
                             got.found, got.hop, got.port, got.idx);
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found || got.hop !== want.hop ||
                got.port !== want.port || got.idx !== want.idx) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Answer mismatch: expected found=%0b hop=%h port=%0d index=%0d",
                             want.found, want.hop, want.port, want.idx);
                    $display("                 actual   found=%0b hop=%h port=%0d index=%0d",
                             got.found, got.hop, got.port, got.idx);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [9:0]  s_entry_index;
    logic [31:0] s_route_prefix_in;
    logic [31:0] s_route_mask_in;
    logic [31:0] s_next_hop_in;
    logic [1:0]  s_port_in;
    logic [31:0] s_dest_addr;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [31:0] m_next_hop_out;
    logic [1:0]  m_port_out;
    logic [9:0]  m_match_index;

    route_checker_t sb;
    bit             written_map [DEPTH];
    logic [31:0]    bases [8];
    int             idle_pct;
    bit             hold_rx_req;
    int             sizes_run;

    longest_prefix_route_lookup i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_entry_index     (s_entry_index),
        .s_route_prefix_in (s_route_prefix_in),
        .s_route_mask_in   (s_route_mask_in),
        .s_next_hop_in     (s_next_hop_in),
        .s_port_in         (s_port_in),
        .s_dest_addr       (s_dest_addr),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_next_hop_out    (m_next_hop_out),
        .m_port_out        (m_port_out),
        .m_match_index     (m_match_index)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly well-formed contiguous masks over a few shared bases, some noise
    function automatic route_word_t make_route(logic [9:0] idx);
        route_word_t w;
        int          len;
        w.op   = lpr_pkg::OP_WRITE;
        w.idx  = idx;
        w.hop  = $urandom;
        w.port = 2'($urandom_range(0, 3));
        w.dest = $urandom;
        if ($urandom_range(0, 99) < 85) begin
            len      = $urandom_range(0, 32);
            w.mask   = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
            w.prefix = bases[$urandom_range(0, 7)] & w.mask;
        end else begin
            w.mask   = $urandom;
            w.prefix = $urandom;
            if ($urandom_range(0, 1) == 1) w.prefix = w.prefix & w.mask;
        end
        return w;
    endfunction

    function automatic route_word_t make_lookup();
        route_word_t w;
        int unsigned n;
        int unsigned j;
        int          pick;
        w    = make_route(10'($urandom_range(0, DEPTH - 1)));
        w.op = lpr_pkg::OP_LOOKUP;
        n    = sb.searched();
        pick = $urandom_range(0, 99);
        if (n != 0 && pick < 70) begin
            j      = $urandom_range(0, n - 1);
            w.dest = sb.prefix_tab[j] | ($urandom & ~sb.mask_tab[j]);
        end else if (pick < 85) begin
            w.dest = bases[$urandom_range(0, 7)] ^ 32'($urandom_range(0, 255));
        end else begin
            w.dest = $urandom;
        end
        return w;
    endfunction

    function automatic route_word_t write_of(logic [9:0] idx, logic [31:0] prefix,
                                             logic [31:0] mask, logic [31:0] hop,
                                             logic [1:0] port);
        route_word_t w;
        w        = make_route(idx);
        w.prefix = prefix;
        w.mask   = mask;
        w.hop    = hop;
        w.port   = port;
        return w;
    endfunction

    function automatic route_word_t lookup_of(logic [31:0] dest);
        route_word_t w;
        w      = make_lookup();
        w.dest = dest;
        return w;
    endfunction

    task automatic send_word(route_word_t w);
        s_op              <= w.op;
        s_entry_index     <= w.idx;
        s_route_prefix_in <= w.prefix;
        s_route_mask_in   <= w.mask;
        s_next_hop_in     <= w.hop;
        s_port_in         <= w.port;
        s_dest_addr       <= w.dest;
        s_valid           <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(w);
        if (w.op == lpr_pkg::OP_WRITE) written_map[w.idx] = 1'b1;
        @(negedge aclk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
    endtask

    task automatic write_cfg(int unsigned v);
        cfg_data  <= 11'(v);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_span(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_answers();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // waits until every pending answer is taken, then lets the bus idle
    task automatic drain_and_settle();
        wait_for_answers();
        repeat (sb.searched() + 10) @(negedge aclk);
    endtask

    task automatic set_table_size(int unsigned v);
        int unsigned eff;
        int unsigned i;
        eff = (v > DEPTH) ? DEPTH : v;
        for (i = 0; i < eff; i++)
            if (!written_map[i]) send_word(make_route(10'(i)));
        drain_and_settle();
        write_cfg(v);
        sizes_run++;
    endtask

    task automatic run_phase(int unsigned size, int count, int pct, pressure_t mode);
        int          k;
        int unsigned n;
        route_word_t w;
        set_table_size(size);
        idle_pct = pct;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) begin
                case (mode)
                    HOLD_RX:  hold_rx_req = 1'b1;
                    PAUSE_TX: wait_for_answers();
                    default: ;
                endcase
            end
            if ($urandom_range(0, 99) < 30) begin
                n = sb.searched();
                if (n != 0 && $urandom_range(0, 1) == 1)
                    w = make_route(10'($urandom_range(0, n - 1)));
                else
                    w = make_route(10'($urandom_range(0, DEPTH - 1)));
            end else begin
                w = make_lookup();
            end
            send_word(w);
        end
    endtask

    // receiver
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // answer monitor
    initial begin
        route_answer_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.found = m_found;
                got.hop   = m_next_hop_out;
                got.port  = m_port_out;
                got.idx   = m_match_index;
                sb.check_answer(got);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int p;
        sb                = new();
        idle_pct          = 0;
        hold_rx_req       = 1'b0;
        sizes_run         = 0;
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        s_valid           = 1'b0;
        s_op              = lpr_pkg::OP_WRITE;
        s_entry_index     = '0;
        s_route_prefix_in = '0;
        s_route_mask_in   = '0;
        s_next_hop_in     = '0;
        s_port_in         = '0;
        s_dest_addr       = '0;
        bases[0] = 32'h0000_0000;
        bases[1] = 32'hFFFF_FFFF;
        for (p = 2; p < 8; p++) bases[p] = $urandom;
        bases[3] = {bases[2][31:16], bases[3][15:0]};
        bases[4] = {bases[2][31:8], bases[4][7:0]};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty table, host route, tie, default route, unmatchable entry
        idle_pct = 20;
        write_cfg(0);
        sizes_run++;
        send_word(lookup_of(32'h0000_0000));
        send_word(write_of(10'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 2'd1));
        send_word(write_of(10'd1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 2'd2));
        send_word(write_of(10'd2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_01FE, 2'd0));
        send_word(write_of(10'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3));
        send_word(write_of(10'd4, 32'h0000_0001, 32'hFFFF_FF00, 32'h1234_5678, 2'd2));
        send_word(write_of(10'd5, 32'hC0A8_0000, 32'hFFFF_FF00, 32'h0000_0000, 2'd0));
        send_word(write_of(10'd6, 32'h0000_0000, 32'h0000_0000, 32'hC0A8_0001, 2'd3));
        send_word(lookup_of(32'h0A01_0203));
        set_table_size(6);
        send_word(lookup_of(32'h0A01_0203));
        send_word(lookup_of(32'h0A02_0304));
        send_word(lookup_of(32'hFFFF_FFFF));
        send_word(lookup_of(32'h0000_0001));
        send_word(lookup_of(32'hC0A8_0042));
        send_word(lookup_of(32'h0000_0000));
        set_table_size(7);
        send_word(lookup_of(32'h0000_0001));
        send_word(lookup_of(32'hFFFF_FFFE));
        send_word(lookup_of(32'h0A01_0000));
        set_table_size(1);
        send_word(lookup_of(32'h0AFF_FFFF));
        send_word(lookup_of(32'h0B00_0000));

        // random: small tables mostly, then full depth, beyond it, a mid size and small again
        for (p = 0; p < 8; p++)
            run_phase($urandom_range(2, 48), 50, (p % 3 == 2) ? 0 : 10 + 5 * p,
                      (p == 1) ? HOLD_RX : ((p == 3) ? PAUSE_TX : PLAIN));
        run_phase(DEPTH, 8, 15, PLAIN);
        run_phase(2047, 8, 15, PLAIN);
        run_phase($urandom_range(DEPTH + 1, 2046), 6, 15, PLAIN);
        run_phase($urandom_range(49, DEPTH - 1), 8, 15, PLAIN);
        run_phase($urandom_range(2, 32), 60, 0, PLAIN);

        drain_and_settle();
        $display("Covered %0d table writes and %0d lookups (%0d routed, %0d unrouted)",
                 sb.writes, sb.lookups, sb.hits, sb.misses);
        $display("Table sizes visited: %0d, from empty to full depth and above it",
                 sizes_run);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Mismatches: %0d, answers still outstanding: %0d",
                     sb.mismatches, sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lpr_pkg.sv
rtl/core/lpr_table.sv
rtl/core/lpr_ctrl.sv
rtl/core/longest_prefix_route_lookup.sv
sim/tb.sv
